// ===== sv/rlse_pkg.sv =====
// Shared types, codes and helpers of the rotator link step engine.
package rlse_pkg;

	// Input operation codes.
	typedef enum logic [1:0] {
		OP_MOVE  = 2'd0,
		OP_RX    = 2'd1,
		OP_POWER = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_STATE_REQ = 3'd0,
		REG_POWER_REQ = 3'd1,
		REG_ACK       = 3'd2,
		REG_NACK      = 3'd3,
		REG_SET_HDR   = 3'd4,
		REG_STEP_LIM  = 3'd5
	} reg_idx_t;

	// Link phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_STATE   = 4'b0010,
		PH_SET_ACK = 4'b0100,
		PH_PWR_ACK = 4'b1000
	} phase_t;

	// Kind of byte sequence that one input item produces.
	typedef enum logic [1:0] {
		JOB_NONE   = 2'd0,
		JOB_SINGLE = 2'd1,
		JOB_ACK_SET = 2'd2,
		JOB_SET    = 2'd3
	} job_kind_t;

	localparam logic [7:0] REPLY_OK   = 8'd65;
	localparam logic [2:0] FRAME_LAST = 3'd6;
	localparam int unsigned JOBQ_DEPTH = 4;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_STATE_REQ = 8'd83;
	localparam logic [7:0]  RST_POWER_REQ = 8'd80;
	localparam logic [7:0]  RST_ACK       = 8'd65;
	localparam logic [7:0]  RST_NACK      = 8'd78;
	localparam logic [7:0]  RST_SET_HDR   = 8'd87;
	localparam logic [15:0] RST_STEP_LIM  = 16'd1820;

	typedef struct packed {
		logic [7:0]  state_req;
		logic [7:0]  power_req;
		logic [7:0]  ack;
		logic [7:0]  nack;
		logic [7:0]  set_hdr;
		logic [15:0] step_lim;
	} cfg_t;

	// One queued job: what to send plus the register snapshot for its results.
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  lead;
		logic        done;
		logic [15:0] cmd_az;
		logic [15:0] cmd_ele;
		logic [15:0] pos_az;
		logic [15:0] pos_ele;
		logic [5:0]  status;
		logic [15:0] errors;
	} job_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        has_byte;
		logic        last;
		logic        cycle_done;
		logic [15:0] az_position;
		logic [15:0] ele_position;
		logic [5:0]  status_bits;
		logic [15:0] checksum_errors;
	} result_t;

	// Move pos toward tgt by at most lim codes.
	function automatic logic [15:0] step_toward(input logic [15:0] pos,
		input logic [15:0] tgt, input logic [15:0] lim);
		logic [15:0] diff;
		logic [15:0] up;
		logic [15:0] dn;
		logic        fwd;
		fwd  = (tgt >= pos);
		diff = fwd ? (tgt - pos) : (pos - tgt);
		up   = pos + lim;
		dn   = pos - lim;
		if (diff > lim) begin
			step_toward = fwd ? up : dn;
		end else begin
			step_toward = tgt;
		end
	endfunction

endpackage

// ===== sv/rlse_front.sv =====
// Front end: accepts input items, runs the link protocol and produces send jobs for the queue.
module rlse_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlse_pkg::cfg_t       cfg,
	input  logic                 accept,
	input  logic [1:0]           op,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          target_az,
	input  logic [15:0]          target_ele,
	output rlse_pkg::job_t       job
);

	rlse_pkg::phase_t phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  frame_q [1:5];
	logic [15:0] tgt_az_q, tgt_ele_q, tgt_az_d, tgt_ele_d;
	logic [15:0] cmd_az_q, cmd_ele_q, cmd_az_d, cmd_ele_d;
	logic [15:0] pos_az_q, pos_ele_q, pos_az_d, pos_ele_d;
	logic [5:0]  status_q, status_d;
	logic [15:0] err_q, err_d;
	logic [15:0] frame_az, frame_ele;
	logic        frame_write;

	assign frame_az  = {frame_q[1], frame_q[2]};
	assign frame_ele = {frame_q[3], frame_q[4]};
	assign frame_write = accept && (rlse_pkg::op_t'(op) == rlse_pkg::OP_RX) &&
		(phase_q == rlse_pkg::PH_STATE) && (cnt_q < rlse_pkg::FRAME_LAST);

	// Protocol step for the item at the input.
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		xor_d     = xor_q;
		tgt_az_d  = tgt_az_q;
		tgt_ele_d = tgt_ele_q;
		cmd_az_d  = cmd_az_q;
		cmd_ele_d = cmd_ele_q;
		pos_az_d  = pos_az_q;
		pos_ele_d = pos_ele_q;
		status_d  = status_q;
		err_d     = err_q;
		job.kind  = rlse_pkg::JOB_NONE;
		job.lead  = 8'd0;
		job.done  = 1'b0;
		unique case (rlse_pkg::op_t'(op))
			rlse_pkg::OP_MOVE: begin
				tgt_az_d  = target_az;
				tgt_ele_d = target_ele;
				phase_d   = rlse_pkg::PH_STATE;
				cnt_d     = 3'd0;
				xor_d     = 8'd0;
				job.kind  = rlse_pkg::JOB_SINGLE;
				job.lead  = cfg.state_req;
			end
			rlse_pkg::OP_POWER: begin
				phase_d  = rlse_pkg::PH_PWR_ACK;
				job.kind = rlse_pkg::JOB_SINGLE;
				job.lead = cfg.power_req;
			end
			rlse_pkg::OP_RX: begin
				unique case (phase_q)
					rlse_pkg::PH_STATE: begin
						if (cnt_q < rlse_pkg::FRAME_LAST) begin
							xor_d = xor_q ^ rx_byte;
							cnt_d = cnt_q + 3'd1;
						end else begin
							cnt_d = 3'd0;
							xor_d = 8'd0;
							if (xor_q != rx_byte) begin
								job.kind = rlse_pkg::JOB_SINGLE;
								job.lead = cfg.nack;
								if (err_q != 16'hFFFF) begin
									err_d = err_q + 16'd1;
								end
							end else begin
								job.kind  = rlse_pkg::JOB_ACK_SET;
								job.lead  = cfg.ack;
								pos_az_d  = frame_az;
								pos_ele_d = frame_ele;
								status_d  = {frame_q[5][7], frame_q[5][4:0]};
								cmd_az_d  = rlse_pkg::step_toward(frame_az, tgt_az_q,
									cfg.step_lim);
								cmd_ele_d = rlse_pkg::step_toward(frame_ele, tgt_ele_q,
									cfg.step_lim);
								phase_d   = rlse_pkg::PH_SET_ACK;
							end
						end
					end
					rlse_pkg::PH_SET_ACK: begin
						if (rx_byte == rlse_pkg::REPLY_OK) begin
							phase_d  = rlse_pkg::PH_IDLE;
							job.done = 1'b1;
						end else begin
							job.kind = rlse_pkg::JOB_SET;
						end
					end
					rlse_pkg::PH_PWR_ACK: begin
						if (rx_byte == rlse_pkg::REPLY_OK) begin
							phase_d  = rlse_pkg::PH_IDLE;
							job.done = 1'b1;
						end else begin
							job.kind = rlse_pkg::JOB_SINGLE;
							job.lead = cfg.power_req;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		job.cmd_az  = cmd_az_d;
		job.cmd_ele = cmd_ele_d;
		job.pos_az  = pos_az_d;
		job.pos_ele = pos_ele_d;
		job.status  = status_d;
		job.errors  = err_d;
	end

	// Protocol state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rlse_pkg::PH_IDLE;
			cnt_q     <= 3'd0;
			xor_q     <= 8'd0;
			tgt_az_q  <= 16'd0;
			tgt_ele_q <= 16'd0;
			cmd_az_q  <= 16'd0;
			cmd_ele_q <= 16'd0;
			pos_az_q  <= 16'd0;
			pos_ele_q <= 16'd0;
			status_q  <= 6'd0;
			err_q     <= 16'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			xor_q     <= xor_d;
			tgt_az_q  <= tgt_az_d;
			tgt_ele_q <= tgt_ele_d;
			cmd_az_q  <= cmd_az_d;
			cmd_ele_q <= cmd_ele_d;
			pos_az_q  <= pos_az_d;
			pos_ele_q <= pos_ele_d;
			status_q  <= status_d;
			err_q     <= err_d;
		end
	end

	// Frame byte store; the first byte and the checksum byte are never read back.
	always_ff @(posedge clk) begin
		for (int i = 1; i <= 5; i++) begin
			if (frame_write && (cnt_q == 3'(i))) begin
				frame_q[i] <= rx_byte;
			end
		end
	end

	// The byte counter never passes the checksum position.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rlse_pkg::FRAME_LAST)
		else $error("frame byte counter out of range");

	// A move item always restarts the state request exchange.
	a_move_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == rlse_pkg::OP_MOVE) |=> phase_q == rlse_pkg::PH_STATE && cnt_q == 3'd0)
		else $error("move item did not restart the state exchange");

	// A good frame leaves the engine waiting for the SET reply.
	a_good_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept && job.kind == rlse_pkg::JOB_ACK_SET |=> phase_q == rlse_pkg::PH_SET_ACK)
		else $error("good frame did not enter SET reply phase");

endmodule

// ===== sv/rlse_jobq.sv =====
// Short job queue between the protocol front end and the byte serializer.
module rlse_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rlse_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output rlse_pkg::job_t job_out,
	output logic           valid
);

	localparam int unsigned PW = $clog2(rlse_pkg::JOBQ_DEPTH);
	localparam int unsigned CW = $clog2(rlse_pkg::JOBQ_DEPTH + 1);

	rlse_pkg::job_t mem_q [rlse_pkg::JOBQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(rlse_pkg::JOBQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign job_out = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(rlse_pkg::JOBQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(rlse_pkg::JOBQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(rlse_pkg::JOBQ_DEPTH))
		else $error("job queue count overflow");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("job queue pointers disagree with empty count");

	// A full queue has its write pointer wrapped around onto the read pointer.
	a_ptr_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (wr_q == rd_q))
		else $error("job queue pointers disagree with full count");

endmodule

// ===== sv/rlse_back.sv =====
// Back end: expands queued jobs into result items through an output register.
module rlse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rlse_pkg::cfg_t    cfg,
	input  rlse_pkg::job_t    job,
	input  logic              job_valid,
	output logic              job_pop,
	output rlse_pkg::result_t res,
	output logic              res_empty,
	input  logic              res_pop
);

	localparam logic [2:0] POS_LEAD   = 3'd0;
	localparam logic [2:0] POS_HDR    = 3'd1;
	localparam logic [2:0] POS_AZ_HI  = 3'd2;
	localparam logic [2:0] POS_AZ_LO  = 3'd3;
	localparam logic [2:0] POS_ELE_HI = 3'd4;
	localparam logic [2:0] POS_ELE_LO = 3'd5;
	localparam logic [2:0] POS_SUM    = 3'd6;

	logic [2:0]        pos_q;
	logic [2:0]        eff_pos, end_pos;
	logic [7:0]        sel_byte, sum_byte;
	logic              has, last_item, load, out_v_q;
	rlse_pkg::result_t next_res;
	rlse_pkg::result_t res_q;

	// A plain SET resend skips the lead byte.
	assign eff_pos = (job.kind == rlse_pkg::JOB_SET && pos_q == POS_LEAD) ? POS_HDR : pos_q;
	assign end_pos = (job.kind == rlse_pkg::JOB_SET || job.kind == rlse_pkg::JOB_ACK_SET) ?
		POS_SUM : POS_LEAD;
	assign sum_byte = cfg.set_hdr ^ job.cmd_az[15:8] ^ job.cmd_az[7:0] ^
		job.cmd_ele[15:8] ^ job.cmd_ele[7:0];

	// Byte select for the current position in the sequence.
	always_comb begin
		unique case (eff_pos)
			POS_LEAD:   sel_byte = job.lead;
			POS_HDR:    sel_byte = cfg.set_hdr;
			POS_AZ_HI:  sel_byte = job.cmd_az[15:8];
			POS_AZ_LO:  sel_byte = job.cmd_az[7:0];
			POS_ELE_HI: sel_byte = job.cmd_ele[15:8];
			POS_ELE_LO: sel_byte = job.cmd_ele[7:0];
			default:    sel_byte = sum_byte;
		endcase
	end

	assign has       = (job.kind != rlse_pkg::JOB_NONE);
	assign last_item = (eff_pos == end_pos);
	assign load      = job_valid && (!out_v_q || res_pop);
	assign job_pop   = load && last_item;

	always_comb begin
		next_res.tx_byte         = has ? sel_byte : 8'd0;
		next_res.has_byte        = has;
		next_res.last            = last_item;
		next_res.cycle_done      = last_item && job.done;
		next_res.az_position     = job.pos_az;
		next_res.ele_position    = job.pos_ele;
		next_res.status_bits     = job.status;
		next_res.checksum_errors = job.errors;
	end

	// Sequence position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_LEAD;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				pos_q   <= last_item ? POS_LEAD : eff_pos + 3'd1;
				out_v_q <= 1'b1;
			end else if (res_pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= next_res;
		end
	end

	assign res       = res_q;
	assign res_empty = !out_v_q;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SUM)
		else $error("sequence position out of range");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job popped from empty queue");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && res_q.cycle_done |-> res_q.last)
		else $error("cycle_done set on a non-final item");

endmodule

// ===== sv/rotator_link_step_engine.sv =====
// Top level of the rotator link step engine: configuration registers and wiring.
// An accepted item is written into the job queue, then its results into the output
// register. Throughput: one input item per cycle while the four-entry job queue has
// room; the serializer gives one result item per cycle while results are popped.
// Reset (arst_n low, asynchronous): link idle, counters and positions zero, queue and
// output empty, configuration registers at their default bytes and step limit.
module rotator_link_step_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] target_az,
	input  logic [15:0] target_ele,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        has_byte,
	output logic        last,
	output logic        cycle_done,
	output logic [15:0] az_position,
	output logic [15:0] ele_position,
	output logic [5:0]  status_bits,
	output logic [15:0] checksum_errors,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	rlse_pkg::cfg_t    cfg_q;
	rlse_pkg::job_t    front_job, head_job;
	rlse_pkg::result_t res;
	logic              accept, q_valid, q_pop;

	assign accept = push && !full;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_req <= rlse_pkg::RST_STATE_REQ;
			cfg_q.power_req <= rlse_pkg::RST_POWER_REQ;
			cfg_q.ack       <= rlse_pkg::RST_ACK;
			cfg_q.nack      <= rlse_pkg::RST_NACK;
			cfg_q.set_hdr   <= rlse_pkg::RST_SET_HDR;
			cfg_q.step_lim  <= rlse_pkg::RST_STEP_LIM;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rlse_pkg::REG_STATE_REQ: cfg_q.state_req <= cfg_data[7:0];
				rlse_pkg::REG_POWER_REQ: cfg_q.power_req <= cfg_data[7:0];
				rlse_pkg::REG_ACK:       cfg_q.ack       <= cfg_data[7:0];
				rlse_pkg::REG_NACK:      cfg_q.nack      <= cfg_data[7:0];
				rlse_pkg::REG_SET_HDR:   cfg_q.set_hdr   <= cfg_data[7:0];
				rlse_pkg::REG_STEP_LIM:  cfg_q.step_lim  <= cfg_data;
				default:                 cfg_q           <= cfg_q;
			endcase
		end
	end

	rlse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.op         (op),
		.rx_byte    (rx_byte),
		.target_az  (target_az),
		.target_ele (target_ele),
		.job        (front_job)
	);

	rlse_jobq u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (front_job),
		.full    (full),
		.pop     (q_pop),
		.job_out (head_job),
		.valid   (q_valid)
	);

	rlse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job       (head_job),
		.job_valid (q_valid),
		.job_pop   (q_pop),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign tx_byte         = res.tx_byte;
	assign has_byte        = res.has_byte;
	assign last            = res.last;
	assign cycle_done      = res.cycle_done;
	assign az_position     = res.az_position;
	assign ele_position    = res.ele_position;
	assign status_bits     = res.status_bits;
	assign checksum_errors = res.checksum_errors;

endmodule
